/* sv/subcube_split_area_exact_assert.svh */
// assertion macros for the subcube split area block
`ifndef SUBCUBE_SPLIT_AREA_EXACT_ASSERT_SVH
`define SUBCUBE_SPLIT_AREA_EXACT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sca assertion failed");
// next-cycle implication
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sca assertion failed");
`else
`define SCA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sca_pkg.sv */
package sca_pkg;

    localparam logic [63:0] S64_TOP  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ROOT_TOP = 64'd3037000499;

    // leaf codes fit 32 bits up to twenty coordinates
    localparam int CODE_BITS   = 32;
    localparam int N_BITS      = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [63:0]          value;
        logic [63:0]          square;
        logic                 ovf;
        logic                 last;
    } t_load;

    typedef struct packed {
        logic              clear;
        logic [N_BITS-1:0] n;
    } t_ctrl;

endpackage

/* sv/subcube_split_area_exact.sv */
// subcube split area, exact integer form
// input channel: an item (one signed 64-bit point value) is taken at a clock edge
// with start high and busy low; values come in point order, 2^n per job
// config channel: i_cfg_valid writes the coordinate count n; ready is always high,
// and a write restarts the job (write only while idle)
// result channel: o_valid pulses for one cycle with area, split coordinate and
// overflow after the last item of a job; the receiver cannot hold it off
// front: registers each item, forms its leaf code and square, pushes it into a
// four-entry queue; busy rises only when the queue is near full
// back: writes leaves into the sum and square memories, then runs the subcube
// fold (FOLD_A, FOLD_B, FOLD_C per folded entry, 3^n - 2^n entries) and the
// descending walk (WALK_RD, WALK_LAT, MUL_LL, MUL_LH, MUL_HH, RAW per code, then
// for a split CH_A and CH_B, CH_C per free coordinate, then FIN); the compute time
// is set by the single read port of the memories and the shared 32x32 multiplier
// items for the next job queue up while a job is computed
// an overflow ends the job with area 0 and coordinate -1, an input one at the job's last item
// reset: n = 8, empty queue, no job in progress; memories need no clearing since
// every entry is written in a job before it is read
module subcube_split_area_exact
    import sca_pkg::*;
#(
    parameter int MAX_COORDINATES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] i_point_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    output logic               o_valid,
    output logic [62:0]        o_area,
    output logic signed [3:0]  o_split_coord,
    output logic               o_overflow
);

    logic                   push;
    t_load                  push_item;
    t_ctrl                  ctrl;
    logic                   q_valid;
    t_load                  q_item;
    logic [QLEVEL_BITS-1:0] q_level;
    logic                   pop;
    logic [3:0]             first_u;

    // accept and classify
    sca_front #(
        .MAX_COORDINATES(MAX_COORDINATES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_point_value(i_point_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_queue_level(q_level),
        .o_push       (push),
        .o_item       (push_item),
        .o_ctrl       (ctrl)
    );

    // short queue decouples loading from the long compute phase
    sca_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_item (q_item),
        .o_level(q_level)
    );

    // store, fold and walk
    sca_back #(
        .MAX_COORDINATES(MAX_COORDINATES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_area       (o_area),
        .o_split_coord(first_u),
        .o_overflow   (o_overflow)
    );

    assign o_split_coord = signed'(first_u);

endmodule

/* sv/sca_front.sv */
module sca_front
    import sca_pkg::*;
#(
    parameter int MAX_COORDINATES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic signed [63:0]     i_point_value,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [3:0]             i_cfg_data,
    input  logic [QLEVEL_BITS-1:0] i_queue_level,
    output logic                   o_push,
    output t_load                  o_item,
    output t_ctrl                  o_ctrl
);

    logic [3:0]                 r_coord;
    logic [N_BITS-1:0]          n_act;
    logic [MAX_COORDINATES-1:0] r_count;
    logic [MAX_COORDINATES-1:0] low_mask;
    logic [CODE_BITS-1:0]       leaf_code;
    logic                       last;
    logic                       accept;
    logic                       r_sv;
    logic [63:0]                r_value;
    logic [63:0]                r_mag;
    logic [CODE_BITS-1:0]       r_code;
    logic                       r_last;
    logic [63:0]                sq_full;

    always_comb begin
        if (r_coord == 4'd0) begin
            n_act = N_BITS'(1);
        end else if (int'(r_coord) > MAX_COORDINATES) begin
            n_act = N_BITS'(MAX_COORDINATES);
        end else begin
            n_act = N_BITS'(r_coord);
        end
    end

    // ternary leaf code: digit 1 for coordinate -1, digit 2 for +1
    always_comb begin
        leaf_code = '0;
        for (int j = 0; j < MAX_COORDINATES; j++) begin
            low_mask[j] = (j < int'(n_act));
            if (j < int'(n_act)) begin
                leaf_code = leaf_code + (r_count[j] ? CODE_BITS'((64'd3 ** j) << 1)
                                                    : CODE_BITS'(64'd3 ** j));
            end
        end
    end

    assign last        = &(r_count | ~low_mask);
    assign o_busy      = (int'(i_queue_level) + int'(r_sv)) >= QUEUE_DEPTH;
    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= 4'd8;
            r_count <= '0;
            r_sv    <= 1'b0;
        end else begin
            r_sv <= accept;
            if (i_cfg_valid) begin
                r_coord <= i_cfg_data;
                r_count <= '0;
            end else if (accept) begin
                r_count <= last ? '0 : r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= i_point_value;
            r_mag   <= i_point_value[63] ? 64'd0 - i_point_value : i_point_value;
            r_code  <= leaf_code;
            r_last  <= last;
        end
    end

    assign sq_full = r_mag[31:0] * r_mag[31:0];

    assign o_push        = r_sv;
    assign o_item.code   = r_code;
    assign o_item.value  = r_value;
    assign o_item.square = sq_full;
    assign o_item.ovf    = r_mag > ROOT_TOP;
    assign o_item.last   = r_last;
    assign o_ctrl.clear  = i_cfg_valid;
    assign o_ctrl.n      = n_act;

endmodule

/* sv/sca_queue.sv */
module sca_queue
    import sca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_load                  i_item,
    input  logic                   i_pop,
    output logic                   o_valid,
    output t_load                  o_item,
    output logic [QLEVEL_BITS-1:0] o_level
);

    t_load                  r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    r_wp;
    logic [PTR_BITS-1:0]    r_rp;
    logic [QLEVEL_BITS-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_item  = r_mem[r_rp];
    assign o_level = r_level;

endmodule

/* sv/sca_back.sv */
`include "subcube_split_area_exact_assert.svh"

module sca_back
    import sca_pkg::*;
#(
    parameter int MAX_COORDINATES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic        i_valid,
    input  t_load       i_item,
    output logic        o_pop,
    output logic        o_valid,
    output logic [62:0] o_area,
    output logic [3:0]  o_split_coord,
    output logic        o_overflow
);

    localparam longint unsigned DEPTH = 64'd3 ** MAX_COORDINATES;
    localparam int CW = $clog2(DEPTH);
    localparam int IW = (MAX_COORDINATES > 1) ? $clog2(MAX_COORDINATES) : 1;

    typedef logic [MAX_COORDINATES-1:0][1:0] t_digits;

    typedef enum logic [3:0] {
        S_IDLE, S_FOLD_A, S_FOLD_B, S_FOLD_C, S_WALK_RD, S_WALK_LAT,
        S_MUL_LL, S_MUL_LH, S_MUL_HH, S_RAW, S_CH_A, S_CH_B, S_CH_C, S_FIN
    } t_state;

    function automatic logic [CW-1:0] code_of(input t_digits d);
        logic [CW-1:0] c;
        c = '0;
        for (int j = 0; j < MAX_COORDINATES; j++) begin
            if (d[j] == 2'd2) begin
                c = c + CW'((64'd3 ** j) << 1);
            end else if (d[j] == 2'd1) begin
                c = c + CW'(64'd3 ** j);
            end
        end
        return c;
    endfunction

    // first element of a fold pass: higher live digits at one, rest zero
    function automatic t_digits pass_digits(input int q, input int n);
        t_digits d;
        for (int j = 0; j < MAX_COORDINATES; j++) begin
            d[j] = (j > q && j < n) ? 2'd1 : 2'd0;
        end
        return d;
    endfunction

    logic [63:0] r_sum_mem [DEPTH];
    logic [63:0] r_sq_mem  [DEPTH];

    t_state            r_state;
    logic              r_ovf_seen;
    logic [IW-1:0]     r_pass;
    t_digits           r_fd;
    logic [63:0]       r_fa_sum;
    logic [63:0]       r_fa_sq;
    logic [CW-1:0]     r_k;
    t_digits           r_wd;
    logic [N_BITS-1:0] r_free;
    logic [63:0]       r_sq;
    logic [63:0]       r_mag;
    logic [127:0]      r_acc;
    logic [63:0]       r_rlo;
    logic              r_rhi_nz;
    logic [IW-1:0]     r_ci;
    logic [63:0]       r_ca;
    logic [63:0]       r_best;
    logic              r_have;
    logic [IW-1:0]     r_choice;
    logic [63:0]       r_rd_sum;
    logic [63:0]       r_rd_sq;
    logic              r_o_valid;
    logic [62:0]       r_o_area;
    logic [3:0]        r_o_first;
    logic              r_o_ovf;

    int                n_int;
    logic [CW-1:0]     p3 [MAX_COORDINATES];
    logic [CW-1:0]     d_code;
    logic [CW-1:0]     fold_p;
    logic [CW-1:0]     tot_code;
    t_digits           init_wd;
    t_digits           nfd;
    logic              fwrap;
    t_digits           nwd;
    logic [N_BITS-1:0] nfree;
    logic [MAX_COORDINATES-1:0] fm;
    logic [IW-1:0]     first_free;
    logic [IW-1:0]     next_free;
    logic              has_next;
    logic              ovf_any;
    logic [63:0]       f_sum;
    logic [63:0]       f_sq;
    logic              f_ovf;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       prod;
    logic [127:0]      a_wide;
    logic [127:0]      raw;
    logic              raw_lt;
    logic              raw_zero;
    logic [63:0]       child;
    logic              better;
    logic [5:0]        sh;
    logic [63:0]       vv;
    logic [63:0]       wval;
    logic              fin_ovf;
    logic              we_sum;
    logic              we_sq;
    logic [CW-1:0]     wr_addr;
    logic [63:0]       wr_sum;
    logic [63:0]       wr_sq;
    logic [CW-1:0]     rd_addr;

    assign n_int = int'(i_ctrl.n);

    always_comb begin
        for (int j = 0; j < MAX_COORDINATES; j++) begin
            p3[j]      = CW'(64'd3 ** j);
            init_wd[j] = (j < n_int) ? 2'd2 : 2'd0;
            fm[j]      = (j < n_int) && (r_wd[j] == 2'd0);
        end
    end

    assign d_code   = code_of(r_fd);
    assign tot_code = code_of(init_wd);
    assign fold_p   = p3[r_pass];

    // lowest free digit, and the next free one above the current child
    always_comb begin
        first_free = '0;
        next_free  = '0;
        has_next   = 1'b0;
        for (int j = MAX_COORDINATES - 1; j >= 0; j--) begin
            if (fm[j]) begin
                first_free = IW'(j);
            end
            if (fm[j] && j > int'(r_ci)) begin
                next_free = IW'(j);
                has_next  = 1'b1;
            end
        end
    end

    // fold odometer: lower digits run 0..2, higher live digits run 1..2
    always_comb begin
        fwrap = 1'b1;
        for (int j = 0; j < MAX_COORDINATES; j++) begin
            nfd[j] = r_fd[j];
            if (j < n_int && j != int'(r_pass) && fwrap) begin
                if (j < int'(r_pass)) begin
                    if (r_fd[j] == 2'd2) begin
                        nfd[j] = 2'd0;
                    end else begin
                        nfd[j] = r_fd[j] + 2'd1;
                        fwrap  = 1'b0;
                    end
                end else begin
                    if (r_fd[j] == 2'd2) begin
                        nfd[j] = 2'd1;
                    end else begin
                        nfd[j] = 2'd2;
                        fwrap  = 1'b0;
                    end
                end
            end
        end
    end

    // walk odometer counts down, digit 0 is a free coordinate
    always_comb begin
        logic borrow;
        borrow = 1'b1;
        nfree  = '0;
        for (int j = 0; j < MAX_COORDINATES; j++) begin
            nwd[j] = r_wd[j];
            if (j < n_int && borrow) begin
                if (r_wd[j] == 2'd0) begin
                    nwd[j] = 2'd2;
                end else begin
                    nwd[j] = r_wd[j] - 2'd1;
                    borrow = 1'b0;
                end
            end
            if (j < n_int && nwd[j] == 2'd0) begin
                nfree = nfree + 1'b1;
            end
        end
    end

    assign ovf_any = r_ovf_seen | i_item.ovf;
    assign o_pop   = (r_state == S_IDLE) && i_valid && !i_ctrl.clear;

    assign f_sum = r_fa_sum + r_rd_sum;
    assign f_sq  = r_fa_sq + r_rd_sq;
    assign f_ovf = ((r_fa_sum[63] == r_rd_sum[63]) && (f_sum[63] != r_fa_sum[63])) || f_sq[63];

    // one 32x32 multiplier, three partial products of mag squared
    always_comb begin
        case (r_state)
            S_MUL_LL: begin
                mul_a = r_mag[31:0];
                mul_b = r_mag[31:0];
            end
            S_MUL_LH: begin
                mul_a = r_mag[31:0];
                mul_b = r_mag[63:32];
            end
            default: begin
                mul_a = r_mag[63:32];
                mul_b = r_mag[63:32];
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign a_wide   = {64'd0, r_sq} << r_free;
    assign raw_lt   = a_wide < r_acc;
    assign raw      = a_wide - r_acc;
    assign raw_zero = (raw == '0);

    assign child  = r_ca + r_rd_sq;
    assign better = !r_have || (child < r_best);

    assign sh      = 6'(2 * n_int - int'(r_free));
    assign vv      = r_rlo << sh;
    assign wval    = vv + r_best;
    assign fin_ovf = r_rhi_nz || (r_rlo > (S64_TOP >> sh)) || (r_best > (S64_TOP - vv));

    always_comb begin
        we_sum  = 1'b0;
        we_sq   = 1'b0;
        wr_addr = r_k;
        wr_sum  = f_sum;
        wr_sq   = wval;
        case (r_state)
            S_IDLE: begin
                we_sum  = o_pop;
                we_sq   = o_pop;
                wr_addr = i_item.code[CW-1:0];
                wr_sum  = i_item.value;
                wr_sq   = i_item.ovf ? 64'd0 : i_item.square;
            end
            S_FOLD_C: begin
                we_sum  = 1'b1;
                we_sq   = 1'b1;
                wr_addr = d_code;
                wr_sq   = f_sq;
            end
            S_RAW: begin
                we_sq = !raw_lt && (raw_zero || r_free == '0);
                wr_sq = 64'd0;
            end
            S_FIN: begin
                we_sq = !fin_ovf;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_FOLD_A: rd_addr = d_code + fold_p;
            S_FOLD_B: rd_addr = d_code + (fold_p << 1);
            S_CH_A:   rd_addr = r_k + p3[r_ci];
            S_CH_B:   rd_addr = r_k + (p3[r_ci] << 1);
            S_CH_C:   rd_addr = r_k + p3[next_free];
            default:  rd_addr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_sum) begin
            r_sum_mem[wr_addr] <= wr_sum;
        end
        if (we_sq) begin
            r_sq_mem[wr_addr] <= wr_sq;
        end
        r_rd_sum <= r_sum_mem[rd_addr];
        r_rd_sq  <= r_sq_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovf_seen <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (i_ctrl.clear) begin
                r_state    <= S_IDLE;
                r_ovf_seen <= 1'b0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (o_pop) begin
                            if (!i_item.last) begin
                                r_ovf_seen <= ovf_any;
                            end else if (ovf_any) begin
                                r_o_valid  <= 1'b1;
                                r_o_area   <= '0;
                                r_o_first  <= 4'hF;
                                r_o_ovf    <= 1'b1;
                                r_ovf_seen <= 1'b0;
                            end else begin
                                r_pass  <= '0;
                                r_fd    <= pass_digits(0, n_int);
                                r_state <= S_FOLD_A;
                            end
                        end
                    end
                    S_FOLD_A: begin
                        r_state <= S_FOLD_B;
                    end
                    S_FOLD_B: begin
                        r_fa_sum <= r_rd_sum;
                        r_fa_sq  <= r_rd_sq;
                        r_state  <= S_FOLD_C;
                    end
                    S_FOLD_C: begin
                        if (f_ovf) begin
                            r_o_valid  <= 1'b1;
                            r_o_area   <= '0;
                            r_o_first  <= 4'hF;
                            r_o_ovf    <= 1'b1;
                            r_ovf_seen <= 1'b0;
                            r_state    <= S_IDLE;
                        end else if (!fwrap) begin
                            r_fd    <= nfd;
                            r_state <= S_FOLD_A;
                        end else if (int'(r_pass) == n_int - 1) begin
                            r_k     <= tot_code;
                            r_wd    <= init_wd;
                            r_free  <= '0;
                            r_state <= S_WALK_RD;
                        end else begin
                            r_pass  <= r_pass + 1'b1;
                            r_fd    <= pass_digits(int'(r_pass) + 1, n_int);
                            r_state <= S_FOLD_A;
                        end
                    end
                    S_WALK_RD: begin
                        r_state <= S_WALK_LAT;
                    end
                    S_WALK_LAT: begin
                        r_sq    <= r_rd_sq;
                        r_mag   <= r_rd_sum[63] ? 64'd0 - r_rd_sum : r_rd_sum;
                        r_state <= S_MUL_LL;
                    end
                    S_MUL_LL: begin
                        r_acc   <= {64'd0, prod};
                        r_state <= S_MUL_LH;
                    end
                    S_MUL_LH: begin
                        r_acc   <= r_acc + ({64'd0, prod} << 33);
                        r_state <= S_MUL_HH;
                    end
                    S_MUL_HH: begin
                        r_acc   <= r_acc + {prod, 64'd0};
                        r_state <= S_RAW;
                    end
                    S_RAW: begin
                        if (raw_lt) begin
                            r_o_valid  <= 1'b1;
                            r_o_area   <= '0;
                            r_o_first  <= 4'hF;
                            r_o_ovf    <= 1'b1;
                            r_ovf_seen <= 1'b0;
                            r_state    <= S_IDLE;
                        end else if (raw_zero || r_free == '0) begin
                            if (r_k == '0) begin
                                r_o_valid  <= 1'b1;
                                r_o_area   <= '0;
                                r_o_first  <= 4'hF;
                                r_o_ovf    <= 1'b0;
                                r_ovf_seen <= 1'b0;
                                r_state    <= S_IDLE;
                            end else begin
                                r_k     <= r_k - 1'b1;
                                r_wd    <= nwd;
                                r_free  <= nfree;
                                r_state <= S_WALK_RD;
                            end
                        end else begin
                            r_rlo    <= raw[63:0];
                            r_rhi_nz <= |raw[127:64];
                            r_have   <= 1'b0;
                            r_best   <= '0;
                            r_ci     <= first_free;
                            r_state  <= S_CH_A;
                        end
                    end
                    S_CH_A: begin
                        r_state <= S_CH_B;
                    end
                    S_CH_B: begin
                        r_ca    <= r_rd_sq;
                        r_state <= S_CH_C;
                    end
                    S_CH_C: begin
                        if (better) begin
                            r_best   <= child;
                            r_choice <= r_ci;
                            r_have   <= 1'b1;
                        end
                        if (has_next) begin
                            r_ci    <= next_free;
                            r_state <= S_CH_B;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                    S_FIN: begin
                        if (fin_ovf) begin
                            r_o_valid  <= 1'b1;
                            r_o_area   <= '0;
                            r_o_first  <= 4'hF;
                            r_o_ovf    <= 1'b1;
                            r_ovf_seen <= 1'b0;
                            r_state    <= S_IDLE;
                        end else if (r_k == '0) begin
                            r_o_valid  <= 1'b1;
                            r_o_area   <= wval[62:0];
                            r_o_first  <= r_have ? 4'(r_choice) : 4'hF;
                            r_o_ovf    <= 1'b0;
                            r_ovf_seen <= 1'b0;
                            r_state    <= S_IDLE;
                        end else begin
                            r_k     <= r_k - 1'b1;
                            r_wd    <= nwd;
                            r_free  <= nfree;
                            r_state <= S_WALK_RD;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_area        = r_o_area;
    assign o_split_coord = r_o_first;
    assign o_overflow    = r_o_ovf;

    `SCA_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_o_valid, !r_o_valid)
    `SCA_ASSERT_SAME(a_no_pop_in_job, i_clk, i_rst_n, r_state != S_IDLE, !o_pop)
    `SCA_ASSERT_SAME(a_ovf_fields, i_clk, i_rst_n, r_o_valid && r_o_ovf, (r_o_area == '0) && (r_o_first == 4'hF))
    `SCA_ASSERT_SAME(a_ovf_flag_cleared, i_clk, i_rst_n, r_o_valid, !r_ovf_seen)

endmodule
